>>> rtl/lsie_pkg.sv
// lsie_pkg: operation, class and status codes plus the structs used by the
// execute unit (rf_wr_t is shared with its register file). No dependencies.
`default_nettype none
package lsie_pkg;

  localparam logic [4:0] FN_ADD  = 5'd0;
  localparam logic [4:0] FN_ADDI = 5'd1;
  localparam logic [4:0] FN_SUB  = 5'd2;
  localparam logic [4:0] FN_SUBI = 5'd3;
  localparam logic [4:0] FN_MUL  = 5'd4;
  localparam logic [4:0] FN_MULI = 5'd5;
  localparam logic [4:0] FN_OR   = 5'd6;
  localparam logic [4:0] FN_ORI  = 5'd7;
  localparam logic [4:0] FN_AND  = 5'd8;
  localparam logic [4:0] FN_ANDI = 5'd9;
  localparam logic [4:0] FN_XOR  = 5'd10;
  localparam logic [4:0] FN_XORI = 5'd11;
  localparam logic [4:0] FN_LDW  = 5'd12;
  localparam logic [4:0] FN_STW  = 5'd13;
  localparam logic [4:0] FN_BZ   = 5'd14;
  localparam logic [4:0] FN_BEQ  = 5'd15;
  localparam logic [4:0] FN_JR   = 5'd16;
  localparam logic [4:0] FN_HALT = 5'd17;

  localparam logic [2:0] CLS_ARITH   = 3'd0;
  localparam logic [2:0] CLS_LOGIC   = 3'd1;
  localparam logic [2:0] CLS_MEM     = 3'd2;
  localparam logic [2:0] CLS_CTRL    = 3'd3;
  localparam logic [2:0] CLS_UNKNOWN = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_ADDR    = 2'd2;

  localparam logic [31:0] PC_STEP = 32'd4;

  typedef struct packed {
    logic        en;
    logic [4:0]  idx;
    logic [31:0] data;
  } rf_wr_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        rf_we;
    logic [4:0]  rf_idx;
    logic        is_load;
    logic [31:0] val;
    logic        mem_we;
    logic [9:0]  mem_idx;
    logic [31:0] mem_val;
    logic [2:0]  cls;
    logic [31:0] ccount;
    logic [31:0] total;
    logic        halted;
    logic [1:0]  status;
  } wb_res_t;

endpackage
`default_nettype wire

>>> rtl/lsie_regfile.sv
// lsie_regfile: register file as a synchronous two-read, one-write memory
// with per-entry valid bits so that unwritten entries read as zero. Uses lsie_pkg.
`default_nettype none
module lsie_regfile
  import lsie_pkg::*;
#(
  parameter int REG_COUNT = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        rd_en_i,
  input  wire logic [$clog2(REG_COUNT)-1:0] rd_a_addr_i,
  input  wire logic [$clog2(REG_COUNT)-1:0] rd_b_addr_i,
  output logic [31:0]      rd_a_data_o,
  output logic [31:0]      rd_b_data_o,
  input  wire rf_wr_t      wr_i
);

  localparam int RW = $clog2(REG_COUNT);

  logic [31:0]          mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_q;
  logic [31:0]          a_q, b_q;
  logic                 a_vld_q, b_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.idx[RW-1:0]] <= wr_i.data;
    end
    if (rd_en_i) begin
      a_q <= mem[rd_a_addr_i];
      b_q <= mem[rd_b_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.idx[RW-1:0]] <= 1'b1;
      end
      if (rd_en_i) begin
        a_vld_q <= vld_q[rd_a_addr_i];
        b_vld_q <= vld_q[rd_b_addr_i];
      end
    end
  end

  assign rd_a_data_o = a_vld_q ? a_q : '0;
  assign rd_b_data_o = b_vld_q ? b_q : '0;

endmodule
`default_nettype wire

>>> rtl/lsie_dmem.sv
// lsie_dmem: data memory, one synchronous read and one write port, with a
// clearing sweep after reset. No package dependencies.
`default_nettype none
module lsie_dmem #(
  parameter int MEM_WORDS = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        rd_en_i,
  input  wire logic [$clog2(MEM_WORDS)-1:0] rd_addr_i,
  output logic [31:0]      rd_data_o,
  input  wire logic        wr_en_i,
  input  wire logic [$clog2(MEM_WORDS)-1:0] wr_addr_i,
  input  wire logic [31:0] wr_data_i,
  output logic             busy_o
);

  localparam int AW = $clog2(MEM_WORDS);

  logic [31:0]   mem [MEM_WORDS];
  logic          clr_q;
  logic [AW-1:0] clr_idx_q;
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;

  always_comb begin
    if (clr_q) begin
      we    = 1'b1;
      waddr = clr_idx_q;
      wdata = '0;
    end else begin
      we    = wr_en_i;
      waddr = wr_addr_i;
      wdata = wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

  // sweep every word to zero once after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else if (clr_q) begin
      if (clr_idx_q == AW'(MEM_WORDS - 1)) begin
        clr_q <= 1'b0;
      end
      clr_idx_q <= clr_idx_q + AW'(1);
    end
  end

  assign busy_o = clr_q;

endmodule
`default_nettype wire

>>> rtl/load_store_isa_execute_unit.sv
// Execute unit for a small load/store instruction set: one decoded instruction
// per request, one result per request. After reset the data memory is swept to
// zero, during which in_ready_o stays low. After that one request is taken per
// clock while results are taken: a request reads the register file as it is
// accepted into the execute stage, and its result is registered into the
// result stage when the execute stage advances, so the throughput is one per
// cycle, bounded by the single execute stage with its multiplier and the data
// memory port. Register writes forward into the execute stage, so dependent
// requests do not stall.
// Depends on lsie_pkg, lsie_regfile and lsie_dmem.
`default_nettype none
module load_store_isa_execute_unit
  import lsie_pkg::*;
#(
  parameter int MEM_WORDS = 1024,
  parameter int REG_COUNT = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [4:0]         func_i,
  input  wire logic [4:0]         src_reg_i,
  input  wire logic [4:0]         second_reg_i,
  input  wire logic [4:0]         dest_reg_i,
  input  wire logic signed [15:0] imm_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [31:0]             next_pc_o,
  output logic                    reg_write_o,
  output logic [4:0]              reg_index_o,
  output logic signed [31:0]      reg_value_o,
  output logic                    mem_write_o,
  output logic [9:0]              mem_index_o,
  output logic signed [31:0]      mem_value_o,
  output logic [2:0]              instr_class_o,
  output logic [31:0]             class_count_o,
  output logic [31:0]             total_count_o,
  output logic                    halted_o,
  output logic [1:0]              status_o
);

  localparam int RW = $clog2(REG_COUNT);
  localparam int AW = $clog2(MEM_WORDS);

  function automatic logic [RW-1:0] reg_mod(input logic [4:0] v);
    logic [5:0] t;
    t = {1'b0, v};
    for (int k = 0; k < 4; k++) begin
      if (t >= 6'(REG_COUNT)) begin
        t = t - 6'(REG_COUNT);
      end
    end
    return t[RW-1:0];
  endfunction

  logic               accept, e_adv, mem_busy;
  logic               e_valid_q, w_valid_q;
  logic [4:0]         e_func_q;
  logic [RW-1:0]      e_rs_q, e_rt_q, e_rd_q;
  logic signed [15:0] e_imm_q;
  logic [31:0]        rf_a, rf_b, dm_rdata;
  logic [31:0]        pc_q, total_q;
  logic [31:0]        cnt_q [4];
  logic               halt_q;
  wb_res_t            w_q, nx;
  rf_wr_t             rf_wr, wb_q;
  logic [31:0]        w_rf_val, a, b, imm32, opb, ea, br_tgt;
  logic [29:0]        ea_word;
  logic               ea_ok, w_fwd;

  assign e_adv      = e_valid_q && (!w_valid_q || out_ready_i);
  assign in_ready_o = !mem_busy && (!e_valid_q || e_adv);
  assign accept     = in_valid_i && in_ready_o;

  lsie_regfile #(
    .REG_COUNT(REG_COUNT)
  ) u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_a_addr_i (reg_mod(src_reg_i)),
    .rd_b_addr_i (reg_mod(second_reg_i)),
    .rd_a_data_o (rf_a),
    .rd_b_data_o (rf_b),
    .wr_i        (rf_wr)
  );

  lsie_dmem #(
    .MEM_WORDS(MEM_WORDS)
  ) u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (e_adv && nx.is_load),
    .rd_addr_i (ea_word[AW-1:0]),
    .rd_data_o (dm_rdata),
    .wr_en_i   (e_adv && nx.mem_we),
    .wr_addr_i (ea_word[AW-1:0]),
    .wr_data_i (b),
    .busy_o    (mem_busy)
  );

  // execute stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (accept) begin
      e_valid_q <= 1'b1;
    end else if (e_adv) begin
      e_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      e_func_q <= func_i;
      e_rs_q   <= reg_mod(src_reg_i);
      e_rt_q   <= reg_mod(second_reg_i);
      e_rd_q   <= reg_mod(dest_reg_i);
      e_imm_q  <= imm_value_i;
    end
  end

  // operand forwarding: result stage first, then the last retired write
  assign w_rf_val = w_q.is_load ? dm_rdata : w_q.val;
  assign w_fwd    = w_valid_q && w_q.rf_we;

  always_comb begin
    if (w_fwd && w_q.rf_idx[RW-1:0] == e_rs_q) begin
      a = w_rf_val;
    end else if (wb_q.en && wb_q.idx[RW-1:0] == e_rs_q) begin
      a = wb_q.data;
    end else begin
      a = rf_a;
    end
    if (w_fwd && w_q.rf_idx[RW-1:0] == e_rt_q) begin
      b = w_rf_val;
    end else if (wb_q.en && wb_q.idx[RW-1:0] == e_rt_q) begin
      b = wb_q.data;
    end else begin
      b = rf_b;
    end
  end

  assign imm32   = 32'(e_imm_q);
  assign opb     = e_func_q[0] ? imm32 : b;
  assign ea      = a + imm32;
  assign ea_word = ea[31:2];
  assign ea_ok   = !ea[31] && (ea_word < 30'(MEM_WORDS));
  assign br_tgt  = pc_q + {imm32[29:0], 2'b00};

  always_comb begin
    nx         = '0;
    nx.next_pc = pc_q + PC_STEP;
    nx.cls     = CLS_ARITH;
    nx.status  = ST_OK;
    case (e_func_q)
      FN_ADD, FN_ADDI, FN_SUB, FN_SUBI, FN_MUL, FN_MULI,
      FN_OR, FN_ORI, FN_AND, FN_ANDI, FN_XOR, FN_XORI: begin
        nx.rf_we  = 1'b1;
        nx.rf_idx = e_func_q[0] ? 5'(e_rt_q) : 5'(e_rd_q);
      end
      default: begin
      end
    endcase
    case (e_func_q)
      FN_ADD, FN_ADDI: nx.val = a + opb;
      FN_SUB, FN_SUBI: nx.val = a - opb;
      FN_MUL, FN_MULI: nx.val = a * opb;
      FN_OR, FN_ORI: begin
        nx.cls = CLS_LOGIC;
        nx.val = a | opb;
      end
      FN_AND, FN_ANDI: begin
        nx.cls = CLS_LOGIC;
        nx.val = a & opb;
      end
      FN_XOR, FN_XORI: begin
        nx.cls = CLS_LOGIC;
        nx.val = a ^ opb;
      end
      FN_LDW: begin
        nx.cls = CLS_MEM;
        if (ea_ok) begin
          nx.rf_we   = 1'b1;
          nx.rf_idx  = 5'(e_rt_q);
          nx.is_load = 1'b1;
        end else begin
          nx.status = ST_ADDR;
        end
      end
      FN_STW: begin
        nx.cls = CLS_MEM;
        if (ea_ok) begin
          nx.mem_we  = 1'b1;
          nx.mem_idx = ea_word[9:0];
          nx.mem_val = b;
        end else begin
          nx.status = ST_ADDR;
        end
      end
      FN_BZ: begin
        nx.cls = CLS_CTRL;
        if (a == '0) begin
          nx.next_pc = br_tgt;
        end
      end
      FN_BEQ: begin
        nx.cls = CLS_CTRL;
        if (a == b) begin
          nx.next_pc = br_tgt;
        end
      end
      FN_JR: begin
        nx.cls     = CLS_CTRL;
        nx.next_pc = a;
      end
      FN_HALT: begin
        nx.cls    = CLS_CTRL;
        nx.halted = 1'b1;
      end
      default: begin
        nx.cls     = CLS_UNKNOWN;
        nx.status  = ST_UNKNOWN;
        nx.next_pc = pc_q;
      end
    endcase
    nx.ccount = (nx.cls == CLS_UNKNOWN) ? '0 : cnt_q[nx.cls[1:0]] + 32'd1;
    nx.total  = total_q + 32'd1;
    // halted: report state, change nothing
    if (halt_q) begin
      nx         = '0;
      nx.next_pc = pc_q;
      nx.cls     = CLS_CTRL;
      nx.ccount  = cnt_q[CLS_CTRL[1:0]];
      nx.total   = total_q;
      nx.halted  = 1'b1;
      nx.status  = ST_OK;
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= '0;
      total_q <= '0;
      halt_q  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (e_adv) begin
      pc_q    <= nx.next_pc;
      total_q <= nx.total;
      halt_q  <= nx.halted;
      if (nx.cls != CLS_UNKNOWN) begin
        cnt_q[nx.cls[1:0]] <= nx.ccount;
      end
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_valid_q <= 1'b0;
    end else if (e_adv) begin
      w_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      w_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_adv) begin
      w_q <= nx;
    end
  end

  assign rf_wr.en   = w_valid_q && out_ready_i && w_q.rf_we;
  assign rf_wr.idx  = w_q.rf_idx;
  assign rf_wr.data = w_rf_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q <= '0;
    end else if (rf_wr.en) begin
      wb_q <= rf_wr;
    end
  end

  assign out_valid_o   = w_valid_q;
  assign next_pc_o     = w_q.next_pc;
  assign reg_write_o   = w_q.rf_we;
  assign reg_index_o   = w_q.rf_idx;
  assign reg_value_o   = w_rf_val;
  assign mem_write_o   = w_q.mem_we;
  assign mem_index_o   = w_q.mem_idx;
  assign mem_value_o   = w_q.mem_val;
  assign instr_class_o = w_q.cls;
  assign class_count_o = w_q.ccount;
  assign total_count_o = w_q.total;
  assign halted_o      = w_q.halted;
  assign status_o      = w_q.status;

  a_no_accept_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) mem_busy |-> !in_ready_o
  ) else $error("request accepted during memory clear");

  a_write_implies_ok: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (reg_write_o || mem_write_o) |-> status_o == ST_OK
  ) else $error("write reported with error status");

  a_halted_no_writes: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && halted_o |-> !reg_write_o && !mem_write_o
  ) else $error("write reported while halted");

  a_pc_holds_when_idle: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !e_adv |=> $stable(pc_q)
  ) else $error("pc changed without an executed request");

endmodule
`default_nettype wire
